[hdl/bcp_pkg.sv]
// ----------------------------------------------------------------------------
// bcp_pkg
// Shared widths, reset values, register indexes and control structs of the
// cascaded balance controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bcp_pkg;

    // Bit-serial multiplier: one coefficient bit per step
    localparam int MUL_STEPS = 32;
    localparam int CNT_W     = $clog2(MUL_STEPS + 1);

    // Accumulator: three signed x unsigned 32-bit products plus bias
    localparam int ACC_W = 66;
    // Sum of two rounded gain products plus a setpoint
    localparam int SUM_W = 50;

    localparam logic [ACC_W-1:0] BIAS_FILT = ACC_W'(64'h0000_0000_8000_0000);
    localparam logic [ACC_W-1:0] BIAS_GAIN = ACC_W'(64'h0000_0000_0000_8000);

    // Complementary filter coefficients, Q0.32
    localparam logic [31:0] K_ACCEL = 32'd22207690;
    localparam logic [31:0] K_GYRO  = 32'd40802189;
    localparam logic [31:0] K_TILT  = 32'd4080218931;

    // Tick kinds carried on s_tuser
    localparam logic KIND_INNER = 1'b0;
    localparam logic KIND_OUTER = 1'b1;

    // State reset values
    localparam logic [31:0] TILT_RESET   = 32'd655;
    localparam logic [31:0] LOWEST_RESET = 32'd6553600;

    // Register reset values
    localparam logic [31:0] RST_ANGLE_GAIN_P = 32'd147456000;
    localparam logic [31:0] RST_ANGLE_GAIN_D = 32'd117965;
    localparam logic [31:0] RST_SPEED_GAIN_P = 32'd66;
    localparam logic [31:0] RST_SPEED_GAIN_D = 32'd0;
    localparam logic [30:0] RST_TILT_MARGIN  = 31'd3277;
    localparam logic [30:0] RST_STILL_LIMIT  = 31'd328;
    localparam logic [30:0] RST_DRIVE_SPEED  = 31'd1310720;
    localparam logic [31:0] RST_TARGET_SPEED = 32'd0;

    localparam int ADDR_W = 5;

    typedef enum logic [2:0] {
        REG_ANGLE_GAIN_P = 3'd0,
        REG_ANGLE_GAIN_D = 3'd1,
        REG_SPEED_GAIN_P = 3'd2,
        REG_SPEED_GAIN_D = 3'd3,
        REG_TILT_MARGIN  = 3'd4,
        REG_STILL_LIMIT  = 3'd5,
        REG_DRIVE_SPEED  = 3'd6,
        REG_TARGET_SPEED = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] angle_gain_p;
        logic [31:0] angle_gain_d;
        logic [31:0] speed_gain_p;
        logic [31:0] speed_gain_d;
        logic [30:0] tilt_margin;
        logic [30:0] still_limit;
        logic [30:0] drive_speed;
        logic [31:0] target_speed;
    } cfg_t;

    typedef struct packed {
        logic start;     // load operands, begin a product
        logic clear;     // preload accumulator with rounding bias
        logic round_hi;  // bias for the filter (2^31) instead of gains (2^15)
    } mac_cmd_t;

endpackage

`default_nettype wire

[hdl/bcp_cfg.sv]
// ----------------------------------------------------------------------------
// bcp_cfg
// APB register file holding gains, tolerances and speed commands.
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_cfg
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [bcp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready,
    output bcp_pkg::cfg_t                  cfg
);

    bcp_pkg::cfg_t     cfg_reg;
    bcp_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = bcp_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_gain_p <= bcp_pkg::RST_ANGLE_GAIN_P;
            cfg_reg.angle_gain_d <= bcp_pkg::RST_ANGLE_GAIN_D;
            cfg_reg.speed_gain_p <= bcp_pkg::RST_SPEED_GAIN_P;
            cfg_reg.speed_gain_d <= bcp_pkg::RST_SPEED_GAIN_D;
            cfg_reg.tilt_margin  <= bcp_pkg::RST_TILT_MARGIN;
            cfg_reg.still_limit  <= bcp_pkg::RST_STILL_LIMIT;
            cfg_reg.drive_speed  <= bcp_pkg::RST_DRIVE_SPEED;
            cfg_reg.target_speed <= bcp_pkg::RST_TARGET_SPEED;
        end
        else if (wr_en)
        begin
            case (idx)
                bcp_pkg::REG_ANGLE_GAIN_P: cfg_reg.angle_gain_p <= pwdata;
                bcp_pkg::REG_ANGLE_GAIN_D: cfg_reg.angle_gain_d <= pwdata;
                bcp_pkg::REG_SPEED_GAIN_P: cfg_reg.speed_gain_p <= pwdata;
                bcp_pkg::REG_SPEED_GAIN_D: cfg_reg.speed_gain_d <= pwdata;
                bcp_pkg::REG_TILT_MARGIN:  cfg_reg.tilt_margin  <= pwdata[30:0];
                bcp_pkg::REG_STILL_LIMIT:  cfg_reg.still_limit  <= pwdata[30:0];
                bcp_pkg::REG_DRIVE_SPEED:  cfg_reg.drive_speed  <= pwdata[30:0];
                bcp_pkg::REG_TARGET_SPEED: cfg_reg.target_speed <= pwdata;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bcp_pkg::REG_ANGLE_GAIN_P: prdata = cfg_reg.angle_gain_p;
            bcp_pkg::REG_ANGLE_GAIN_D: prdata = cfg_reg.angle_gain_d;
            bcp_pkg::REG_SPEED_GAIN_P: prdata = cfg_reg.speed_gain_p;
            bcp_pkg::REG_SPEED_GAIN_D: prdata = cfg_reg.speed_gain_d;
            bcp_pkg::REG_TILT_MARGIN:  prdata = {1'b0, cfg_reg.tilt_margin};
            bcp_pkg::REG_STILL_LIMIT:  prdata = {1'b0, cfg_reg.still_limit};
            bcp_pkg::REG_DRIVE_SPEED:  prdata = {1'b0, cfg_reg.drive_speed};
            bcp_pkg::REG_TARGET_SPEED: prdata = cfg_reg.target_speed;
            default:                   prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[hdl/bcp_mac.sv]
// ----------------------------------------------------------------------------
// bcp_mac
// Bit-serial multiply-accumulate: signed 32-bit value times unsigned 32-bit
// coefficient, one coefficient bit per cycle, into a wide accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_mac
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire bcp_pkg::mac_cmd_t        cmd,
    input  wire logic [31:0]              value,
    input  wire logic [31:0]              coef,
    output logic      [bcp_pkg::ACC_W-1:0] acc,
    output logic                          done
);

    logic [bcp_pkg::ACC_W-1:0] mcand_reg;
    logic [31:0]               mplier_reg;
    logic [bcp_pkg::ACC_W-1:0] acc_reg;
    logic [bcp_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;

    assign acc  = acc_reg;
    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == bcp_pkg::CNT_W'(1));
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= bcp_pkg::CNT_W'(bcp_pkg::MUL_STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg  <= cnt_reg - bcp_pkg::CNT_W'(1);
                busy_reg <= (cnt_reg != bcp_pkg::CNT_W'(1));
            end
        end
    end

    // Shift multiplicand left, coefficient right, add on each set bit
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mcand_reg  <= {{(bcp_pkg::ACC_W-32){value[31]}}, value};
            mplier_reg <= coef;
            if (cmd.clear)
                acc_reg <= cmd.round_hi ? bcp_pkg::BIAS_FILT : bcp_pkg::BIAS_GAIN;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= {mcand_reg[bcp_pkg::ACC_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[31:1]};
        end
    end

endmodule

`default_nettype wire

[hdl/balance_cascade_pid.sv]
// ----------------------------------------------------------------------------
// balance_cascade_pid
// Two-wheel balancing controller: outer speed PD with setpoint clamp and idle
// tilt tracking, inner complementary tilt filter and angle PD, Q16.16.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | content
//  --------+-----+--------------------+-------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tick: kind, IMU sample / wheel speeds
//  m_*     | out | m_tvalid/m_tready  | motor accel and speed commands
//  APB     | in  | psel/penable       | gains, tolerances, speed commands
//
//  Products go through one bit-serial multiplier, one coefficient bit per
//  cycle, with a load and a handoff step around each product. An inner tick
//  takes five products, an outer tick two.
//  One tick is worked at a time; s_tready is high only while idle.
//  A finished result sits in the output register; the next tick is accepted
//  while it waits, and an inner tick only stalls at its very end if the
//  previous result has still not been taken.
//  Reset (asynchronous, active low) restores registers and loop state.
// ----------------------------------------------------------------------------
`default_nettype none

module balance_cascade_pid
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // input ticks
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // [31:0] accel_z, [63:32] gyro_pitch, [95:64] wheel_speed_one,
    // [127:96] wheel_speed_two
    input  wire logic [127:0]               s_tdata,
    // [0] kind
    input  wire logic [0:0]                 s_tuser,
    // motor commands
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // [31:0] accel_motor_one, [63:32] accel_motor_two,
    // [95:64] speed_motor_one, [127:96] speed_motor_two
    output logic      [127:0]               m_tdata,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bcp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready
);

    localparam int   SW         = bcp_pkg::SUM_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_O_SPD,
        S_I_TILT,
        S_ERR,
        S_DIFF,
        S_O_ADD,
        S_O_CLAMP,
        S_I_OUT
    } state_t;

    // which product the multiplier is working on
    typedef enum logic [2:0] {
        OP_KA,
        OP_KG,
        OP_KC,
        OP_GP,
        OP_GD
    } op_t;

    function automatic logic [31:0] sat33(input logic [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic [31:0] sat34(input logic [33:0] v);
        if (!((&v[33:31]) || !(|v[33:31])))
            return v[33] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return v[31:0];
    endfunction

    function automatic logic [31:0] sat_sum(input logic [SW-1:0] v);
        if (!((&v[SW-1:31]) || !(|v[SW-1:31])))
            return v[SW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return v[31:0];
    endfunction

    bcp_pkg::cfg_t     cfg;
    bcp_pkg::mac_cmd_t mac_cmd;
    logic [31:0]       mac_value;
    logic [31:0]       mac_coef;
    logic [bcp_pkg::ACC_W-1:0] mac_acc;
    logic              mac_done;

    state_t            state_reg;
    op_t               op_reg;
    logic              kind_reg;
    logic              m_valid_reg;

    // loop state
    logic [31:0]       tilt_estimate_reg;
    logic [31:0]       angle_error_last_reg;
    logic [31:0]       tilt_setpoint_reg;
    logic [31:0]       idle_tilt_reg;
    logic [31:0]       speed_error_last_reg;
    logic [31:0]       lowest_speed_reg;

    // working registers
    logic [31:0]       x_reg;      // accel_z or wheel_speed_one
    logic [31:0]       y_reg;      // gyro_pitch or wheel_speed_two
    logic [31:0]       meas_reg;   // forward speed or new tilt
    logic [31:0]       mag_reg;
    logic [31:0]       err_reg;
    logic [31:0]       diff_reg;
    logic signed [SW-1:0] sum_reg;
    logic signed [32:0] hi_reg;
    logic signed [32:0] lo_reg;
    logic [127:0]      m_data_reg;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [32:0]       wdiff;
    logic [31:0]       err_lhs;
    logic [32:0]       err33;
    logic [31:0]       last_err;
    logic [32:0]       diff33;
    logic [SW-1:0]     prod_rnd;
    logic signed [SW-1:0] hi_ext;
    logic signed [SW-1:0] lo_ext;
    logic [32:0]       clamped;
    logic [31:0]       new_setpoint;
    logic [31:0]       pid;
    logic [31:0]       pid_neg;
    logic [31:0]       spd;

    bcp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcp_mac u_mac
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .value (mac_value),
        .coef  (mac_coef),
        .acc   (mac_acc),
        .done  (mac_done)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign out_free = !m_valid_reg || m_tready;
    // new command goes into the output register this cycle
    assign out_load = (state_reg == S_I_OUT) && out_free;

    // multiplier operand select
    always_comb
    begin
        mac_cmd.start    = (state_reg == S_MUL_GO);
        mac_cmd.clear    = op_reg inside {OP_KA, OP_GP, OP_GD};
        mac_cmd.round_hi = (op_reg == OP_KA);
        case (op_reg)
            OP_KA:
            begin
                mac_value = x_reg;
                mac_coef  = bcp_pkg::K_ACCEL;
            end
            OP_KG:
            begin
                mac_value = y_reg;
                mac_coef  = bcp_pkg::K_GYRO;
            end
            OP_KC:
            begin
                mac_value = tilt_estimate_reg;
                mac_coef  = bcp_pkg::K_TILT;
            end
            OP_GP:
            begin
                mac_value = err_reg;
                mac_coef  = (kind_reg == bcp_pkg::KIND_OUTER) ? cfg.speed_gain_p
                                                              : cfg.angle_gain_p;
            end
            OP_GD:
            begin
                mac_value = diff_reg;
                mac_coef  = (kind_reg == bcp_pkg::KIND_OUTER) ? cfg.speed_gain_d
                                                              : cfg.angle_gain_d;
            end
            default:
            begin
                mac_value = '0;
                mac_coef  = '0;
            end
        endcase
    end

    // datapath arithmetic, one add or compare level per state
    always_comb
    begin
        // forward speed: floor((w2 - w1) / 2)
        wdiff    = {y_reg[31], y_reg} - {x_reg[31], x_reg};
        err_lhs  = (kind_reg == bcp_pkg::KIND_OUTER) ? cfg.target_speed : tilt_setpoint_reg;
        err33    = {err_lhs[31], err_lhs} - {meas_reg[31], meas_reg};
        last_err = (kind_reg == bcp_pkg::KIND_OUTER) ? speed_error_last_reg
                                                     : angle_error_last_reg;
        diff33   = {err_reg[31], err_reg} - {last_err[31], last_err};
        // gain product already carries the 2^15 rounding bias
        prod_rnd = mac_acc[16 +: SW];

        // setpoint clamp to idle +/- tolerance
        hi_ext = {{(SW-33){hi_reg[32]}}, hi_reg};
        lo_ext = {{(SW-33){lo_reg[32]}}, lo_reg};
        if (sum_reg > hi_ext)
            clamped = hi_reg;
        else if (sum_reg < lo_ext)
            clamped = lo_reg;
        else
            clamped = sum_reg[32:0];
        new_setpoint = sat33(clamped);

        pid     = sat_sum(sum_reg);
        pid_neg = (pid == 32'h8000_0000) ? 32'h7FFF_FFFF : (32'd0 - pid);
        spd     = pid[31] ? (32'd0 - {1'b0, cfg.drive_speed}) : {1'b0, cfg.drive_speed};
    end

    // sequencer, loop state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            op_reg               <= OP_KA;
            kind_reg             <= bcp_pkg::KIND_INNER;
            m_valid_reg          <= 1'b0;
            m_data_reg           <= '0;
            tilt_estimate_reg    <= '0;
            angle_error_last_reg <= '0;
            tilt_setpoint_reg    <= bcp_pkg::TILT_RESET;
            idle_tilt_reg        <= bcp_pkg::TILT_RESET;
            speed_error_last_reg <= '0;
            lowest_speed_reg     <= bcp_pkg::LOWEST_RESET;
        end
        else
        begin
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_tready)
                m_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        kind_reg <= s_tuser[0];
                        op_reg   <= OP_KA;
                        state_reg <= (s_tuser[0] == bcp_pkg::KIND_OUTER) ? S_O_SPD : S_MUL_GO;
                    end
                end
                S_MUL_GO:
                begin
                    state_reg <= S_MUL_WAIT;
                end
                S_MUL_WAIT:
                begin
                    if (mac_done)
                    begin
                        case (op_reg)
                            OP_KA:
                            begin
                                op_reg    <= OP_KG;
                                state_reg <= S_MUL_GO;
                            end
                            OP_KG:
                            begin
                                op_reg    <= OP_KC;
                                state_reg <= S_MUL_GO;
                            end
                            OP_KC:
                            begin
                                state_reg <= S_I_TILT;
                            end
                            OP_GP:
                            begin
                                op_reg    <= OP_GD;
                                state_reg <= S_MUL_GO;
                            end
                            OP_GD:
                            begin
                                state_reg <= (kind_reg == bcp_pkg::KIND_OUTER) ? S_O_ADD
                                                                               : S_I_OUT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_O_SPD:
                begin
                    state_reg <= S_ERR;
                end
                S_I_TILT:
                begin
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    op_reg    <= OP_GP;
                    state_reg <= S_MUL_GO;
                end
                S_O_ADD:
                begin
                    state_reg <= S_O_CLAMP;
                end
                S_O_CLAMP:
                begin
                    tilt_setpoint_reg    <= new_setpoint;
                    speed_error_last_reg <= err_reg;
                    // idle tilt follows the setpoint at a new low speed
                    if ((mag_reg < {1'b0, cfg.still_limit}) && (mag_reg < lowest_speed_reg))
                    begin
                        idle_tilt_reg    <= new_setpoint;
                        lowest_speed_reg <= mag_reg;
                    end
                    state_reg <= S_IDLE;
                end
                S_I_OUT:
                begin
                    if (out_free)
                    begin
                        m_data_reg           <= {32'd0 - spd, spd, pid_neg, pid};
                        tilt_estimate_reg    <= meas_reg;
                        angle_error_last_reg <= err_reg;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    x_reg <= (s_tuser[0] == bcp_pkg::KIND_OUTER) ? s_tdata[95:64]
                                                                 : s_tdata[31:0];
                    y_reg <= (s_tuser[0] == bcp_pkg::KIND_OUTER) ? s_tdata[127:96]
                                                                 : s_tdata[63:32];
                end
            end
            S_MUL_WAIT:
            begin
                if (mac_done)
                begin
                    if (op_reg == OP_GP)
                        sum_reg <= prod_rnd;
                    else if (op_reg == OP_GD)
                        sum_reg <= sum_reg + prod_rnd;
                end
            end
            S_O_SPD:
            begin
                meas_reg <= wdiff[32:1];
            end
            S_I_TILT:
            begin
                // filter sum carries the 2^31 bias, floor shift by 32
                meas_reg <= sat34(mac_acc[65:32]);
            end
            S_ERR:
            begin
                err_reg <= sat33(err33);
                mag_reg <= meas_reg[31] ? (32'd0 - meas_reg) : meas_reg;
            end
            S_DIFF:
            begin
                diff_reg <= sat33(diff33);
            end
            S_O_ADD:
            begin
                sum_reg <= sum_reg + {{(SW-32){idle_tilt_reg[31]}}, idle_tilt_reg};
                hi_reg  <= {idle_tilt_reg[31], idle_tilt_reg} + {2'b00, cfg.tilt_margin};
                lo_reg  <= {idle_tilt_reg[31], idle_tilt_reg} - {2'b00, cfg.tilt_margin};
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire
